@@ rtl/core/dtt_pkg.sv @@
// ----------------------------------------------------------------------------
// DIV/TIMA interval timer package
// Shared types, register indexes, constants and the period lookup.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 8;
  localparam int unsigned StepWidth    = 4;

  localparam logic [CfgIdxWidth-1:0] CFG_TIMER_ENABLE = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_CLOCK_SELECT = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_MODULO_VALUE = 2'd2;

  localparam logic OP_ADVANCE   = 1'b0;
  localparam logic OP_DIV_CLEAR = 1'b1;

  localparam logic [StepWidth-1:0] MaxStepCycles = 4'd15;

  localparam logic [1:0] SEL_1024 = 2'd0;
  localparam logic [1:0] SEL_16   = 2'd1;
  localparam logic [1:0] SEL_64   = 2'd2;
  localparam logic [1:0] SEL_256  = 2'd3;

  localparam logic [10:0] PrescaleInc = 11'd4;

  typedef struct packed {
    logic       timer_enable;
    logic [1:0] clock_select;
    logic [7:0] modulo_value;
  } dtt_cfg_t;

  typedef struct packed {
    logic [5:0]  sub_div_count;
    logic [7:0]  div_count;
    logic [10:0] prescale_accum;
    logic [7:0]  tima_count;
    logic        reload_pending;
  } dtt_timer_t;

  function automatic logic [10:0] period_of(input logic [1:0] sel);
    logic [10:0] period;
    case (sel)
      SEL_16:   period = 11'd16;
      SEL_64:   period = 11'd64;
      SEL_256:  period = 11'd256;
      SEL_1024: period = 11'd1024;
      default:  period = 11'd1024;
    endcase
    return period;
  endfunction

endpackage

@@ rtl/core/div_tima_interval_timer.sv @@
// ----------------------------------------------------------------------------
// DIV/TIMA interval timer
// Console-style divider and TIMA timer stepped one M-cycle per clock while running.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// in       sink       in_valid_i/in_stall_o   opcode_i, m_cycles_i
// out      source     out_valid_o/out_stall_i div_value_o, tima_value_o, timer_irq_o
// cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An advance item runs the M-cycle unit, which steps the timer once per
// clock; then the result moves to the output register once it is free.
// A divider clear zeroes div_count only. Input stalls while an item is in work and
// while the output register still holds an untaken transfer at completion.
// Reset clears all timer state and config to zero.
// ----------------------------------------------------------------------------
module div_tima_interval_timer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             opcode_i,
  input  logic [dtt_pkg::StepWidth-1:0]    m_cycles_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [7:0]                       div_value_o,
  output logic [7:0]                       tima_value_o,
  output logic                             timer_irq_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dtt_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [dtt_pkg::CfgDataWidth-1:0] cfg_data_i
);
  import dtt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } dtt_fsm_e;

  dtt_fsm_e             state_q, state_d;
  dtt_cfg_t             cfg;
  dtt_timer_t           timer_q, timer_d, timer_step;
  logic                 step_reload;
  logic [StepWidth-1:0] remain_q, remain_d;
  logic                 irq_q, irq_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           div_out_q, div_out_d;
  logic [7:0]           tima_out_q, tima_out_d;
  logic                 irq_out_q, irq_out_d;
  logic                 in_xfer;
  logic                 out_free;

  dtt_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dtt_mcycle u_mcycle (
    .cfg_i   (cfg),
    .cur_i   (timer_q),
    .nxt_o   (timer_step),
    .reload_o(step_reload)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d     = state_q;
    timer_d     = timer_q;
    remain_d    = remain_q;
    irq_d       = irq_q;
    out_valid_d = out_valid_q & out_stall_i;
    div_out_d   = div_out_q;
    tima_out_d  = tima_out_q;
    irq_out_d   = irq_out_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          irq_d   = 1'b0;
          state_d = ST_RUN;
          if (opcode_i == OP_DIV_CLEAR) begin
            timer_d.div_count = 8'd0;
            remain_d          = '0;
          end else begin
            remain_d = (m_cycles_i > MaxStepCycles) ? MaxStepCycles : m_cycles_i;
          end
        end
      end
      ST_RUN: begin
        if (remain_q != '0) begin
          timer_d  = timer_step;
          irq_d    = irq_q | step_reload;
          remain_d = remain_q - 1'b1;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          div_out_d   = timer_q.div_count;
          tima_out_d  = timer_q.tima_count;
          irq_out_d   = irq_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      timer_q     <= '0;
      remain_q    <= '0;
      irq_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      timer_q     <= timer_d;
      remain_q    <= remain_d;
      irq_q       <= irq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_out_q  <= div_out_d;
    tima_out_q <= tima_out_d;
    irq_out_q  <= irq_out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign div_value_o  = div_out_q;
  assign tima_value_o = tima_out_q;
  assign timer_irq_o  = irq_out_q;

endmodule

@@ rtl/core/dtt_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// DIV/TIMA timer configuration registers
// Holds timer enable, clock select and modulo, written over the config port.
// ----------------------------------------------------------------------------
module dtt_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dtt_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [dtt_pkg::CfgDataWidth-1:0] cfg_data_i,
  output dtt_pkg::dtt_cfg_t                cfg_o
);
  import dtt_pkg::*;

  dtt_cfg_t cfg_q, cfg_d;
  logic     wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (cfg_index_i)
        CFG_TIMER_ENABLE: cfg_d.timer_enable = cfg_data_i[0];
        CFG_CLOCK_SELECT: cfg_d.clock_select = cfg_data_i[1:0];
        CFG_MODULO_VALUE: cfg_d.modulo_value = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/dtt_mcycle.sv @@
// ----------------------------------------------------------------------------
// DIV/TIMA timer M-cycle unit
// Advances divider, prescaler and TIMA by one M-cycle, including reload.
// ----------------------------------------------------------------------------
module dtt_mcycle (
  input  dtt_pkg::dtt_cfg_t   cfg_i,
  input  dtt_pkg::dtt_timer_t cur_i,
  output dtt_pkg::dtt_timer_t nxt_o,
  output logic                reload_o
);
  import dtt_pkg::*;

  logic [10:0] period;
  logic [10:0] accum_inc;
  logic [7:0]  tima_inc;

  assign period = period_of(cfg_i.clock_select);

  always_comb begin
    nxt_o     = cur_i;
    reload_o  = 1'b0;
    accum_inc = cur_i.prescale_accum + PrescaleInc;
    tima_inc  = 8'd0;

    nxt_o.sub_div_count = cur_i.sub_div_count + 6'd1;
    if (nxt_o.sub_div_count == 6'd0) begin
      nxt_o.div_count = cur_i.div_count + 8'd1;
    end

    // reload from modulo via reload_pending, which is set on overflow
    if (cur_i.reload_pending) begin
      nxt_o.tima_count     = cfg_i.modulo_value;
      nxt_o.reload_pending = 1'b0;
      reload_o             = 1'b1;
    end

    tima_inc = nxt_o.tima_count + 8'd1;
    if (cfg_i.timer_enable) begin
      nxt_o.prescale_accum = accum_inc;
      if (accum_inc >= period) begin
        nxt_o.prescale_accum = accum_inc - period;
        nxt_o.tima_count     = tima_inc;
        if (tima_inc == 8'd0) begin
          nxt_o.reload_pending = 1'b1;
        end
      end
    end
  end

endmodule
